/* rtl/core/snrm_pkg.sv */
package snrm_pkg;

  localparam logic [1:0] OP_XLATE = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  rule_index;
    logic [7:0]  protocol;
    logic [31:0] addr_a;
    logic [15:0] port_a;
    logic [31:0] addr_b;
    logic [15:0] port_b;
    logic        nat_direction;
    logic        rule_enable;
  } snrm_in_t;

  typedef struct packed {
    logic [31:0] out_src_addr;
    logic [15:0] out_src_port;
    logic [31:0] out_dst_addr;
    logic [15:0] out_dst_port;
    logic        hit;
    logic [3:0]  hit_index;
  } snrm_out_t;

  typedef struct packed {
    logic        dir;
    logic [7:0]  protocol;
    logic [31:0] match_addr;
    logic [15:0] match_port;
    logic [31:0] xlat_addr;
    logic [15:0] xlat_port;
  } snrm_rule_t;

endpackage

/* rtl/core/static_nat_rule_match_unit.sv */
// Channel   Direction  Ports                       Transfer when
// input     in         in_valid, in_stall, in_data in_valid && !in_stall
// result    out        out_valid, out_stall, out_data out_valid && !out_stall
//
// A translate walks the rule table one entry per cycle through a single
// registered read port and one comparator, and stops at the first matching
// entry or after the last one. Its result then waits in the done state until
// the output register is free and loads there; the input frees up in the
// cycle after that load. A rule write, a clear or an unused opcode goes
// straight to the done state and loads its result the same way.
// Reset (rst_n low, synchronous) clears the valid marks, the sequencer and
// the output valid flag; rule contents and result data are left as they are.
// A stalled result sits in the output register while the next item is taken;
// the sequencer only waits when it has a new result and the register is full.
module static_nat_rule_match_unit
  import snrm_pkg::*;
#(
  parameter int RULES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  snrm_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output snrm_out_t out_data
);

  localparam int IW = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int CW = $clog2(RULES + 1);

  // sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [RULES-1:0] valid_r;
  snrm_rule_t       rule_mem [RULES];
  snrm_rule_t       rd_rule_r;
  logic             rd_vld_r;
  logic [IW-1:0]    rd_idx_r;
  logic             cmp_pend_r;
  logic [CW-1:0]    issue_r;
  snrm_in_t         hdr_r;
  snrm_out_t        res_r;
  snrm_out_t        out_r;
  logic             out_valid_r;

  logic             in_xfer;
  logic             issue_go;
  logic [IW-1:0]    rd_addr;
  logic             wr_go;
  logic [IW-1:0]    wr_addr;
  logic             has_ports;
  logic [15:0]      sp;
  logic [15:0]      dp;
  logic             rule_hit;
  logic             scan_end;
  logic             res_load;
  snrm_out_t        echo;
  snrm_out_t        hit_res;
  snrm_rule_t       wr_rule;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // table write port
  assign wr_go   = in_xfer && (in_data.opcode == OP_WRITE) && (in_data.rule_index < RULES);
  assign wr_addr = IW'(in_data.rule_index);
  assign wr_rule = '{dir: in_data.nat_direction, protocol: in_data.protocol,
                     match_addr: in_data.addr_a, match_port: in_data.port_a,
                     xlat_addr: in_data.addr_b, xlat_port: in_data.port_b};

  // walk the table one entry per cycle
  assign issue_go = (state_r == ST_SCAN) && (issue_r < CW'(RULES));
  assign rd_addr  = issue_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (wr_go) begin
      rule_mem[wr_addr] <= wr_rule;
    end
    if (issue_go) begin
      rd_rule_r <= rule_mem[rd_addr];
      rd_idx_r  <= rd_addr;
    end
  end

  // compare stage on the entry read last cycle
  assign has_ports = (hdr_r.protocol == PROTO_TCP) || (hdr_r.protocol == PROTO_UDP);
  assign sp = has_ports ? hdr_r.port_a : 16'd0;
  assign dp = has_ports ? hdr_r.port_b : 16'd0;

  always_comb begin
    rule_hit = 1'b0;
    if (cmp_pend_r && rd_vld_r && (rd_rule_r.protocol == hdr_r.protocol)) begin
      if (!rd_rule_r.dir) begin
        rule_hit = (rd_rule_r.match_addr == hdr_r.addr_a) && (rd_rule_r.match_port == sp);
      end else begin
        rule_hit = (rd_rule_r.match_addr == hdr_r.addr_b) && (rd_rule_r.match_port == dp);
      end
    end
  end

  assign scan_end = (state_r == ST_SCAN) && !cmp_pend_r && (issue_r == CW'(RULES));

  always_comb begin
    echo.out_src_addr = hdr_r.addr_a;
    echo.out_src_port = hdr_r.port_a;
    echo.out_dst_addr = hdr_r.addr_b;
    echo.out_dst_port = hdr_r.port_b;
    echo.hit          = 1'b0;
    echo.hit_index    = 4'd0;
    hit_res           = echo;
    hit_res.hit       = 1'b1;
    hit_res.hit_index = 4'(rd_idx_r);
    if (!rd_rule_r.dir) begin
      hit_res.out_src_addr = rd_rule_r.xlat_addr;
      if (has_ports) begin
        hit_res.out_src_port = rd_rule_r.xlat_port;
      end
    end else begin
      hit_res.out_dst_addr = rd_rule_r.xlat_addr;
      if (has_ports) begin
        hit_res.out_dst_port = rd_rule_r.xlat_port;
      end
    end
  end

  assign res_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_data.opcode == OP_XLATE) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (rule_hit || scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      cmp_pend_r  <= 1'b0;
      rd_vld_r    <= 1'b0;
      issue_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        unique case (in_data.opcode)
          OP_WRITE: begin
            if (wr_go) begin
              valid_r[wr_addr] <= in_data.rule_enable;
            end
          end
          OP_CLEAR: valid_r <= '0;
          default: ;
        endcase
      end
      if (in_xfer) begin
        issue_r    <= '0;
        cmp_pend_r <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        cmp_pend_r <= issue_go && !rule_hit;
        if (issue_go) begin
          issue_r  <= issue_r + CW'(1);
          rd_vld_r <= valid_r[rd_addr];
        end
      end else begin
        cmp_pend_r <= 1'b0;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: latch header, hold result until the output register frees up
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hdr_r <= in_data;
    end
    if (state_r == ST_IDLE) begin
      // echo of the incoming transfer; a walk overwrites it
      res_r <= '{out_src_addr: in_data.addr_a, out_src_port: in_data.port_a,
                 out_dst_addr: in_data.addr_b, out_dst_port: in_data.port_b,
                 hit: 1'b0, hit_index: 4'd0};
    end else if (state_r == ST_SCAN) begin
      if (rule_hit) begin
        res_r <= hit_res;
      end else begin
        res_r <= echo;
      end
    end
    if (res_load) begin
      out_r <= (state_r == ST_DONE) ? res_r : out_r;
    end
  end

  // a compare always follows an issued read
  a_issue_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_pend_r |-> (issue_r != '0))
    else $error("compare pending with no entry issued");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (issue_r <= CW'(RULES)))
    else $error("table walk ran past the last rule");

  a_xlate_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_data.opcode == OP_XLATE)) |=> (state_r == ST_SCAN) && (issue_r == '0))
    else $error("translate did not start a table walk");

  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.hit) |-> (out_r.hit_index == 4'd0))
    else $error("miss carries a nonzero rule index");

endmodule

/* sim/static_nat_rule_match_unit_tb.sv */
module static_nat_rule_match_unit_tb;
  import snrm_pkg::*;

  localparam int RULES = 16;
  localparam int N_RANDOM = 1000;
  localparam int WATCHDOG_LIMIT = 2000;
  // Time to linger after the last expected result, to catch a stray extra one.
  localparam int DRAIN_CYCLES = 40;
  // Long receiver hold-off: starts once this many transfers went in.
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 300;

  // Opcode the block does not define; it must behave as a plain echo.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Protocols without ports: match on port zero, never rewrite the ports.
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_RESERVED = 8'd255;

  localparam snrm_out_t NO_WANT = '0;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  snrm_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  snrm_out_t out_data;

  static_nat_rule_match_unit #(.RULES(RULES)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Shadow copy of the rule table, updated as each transfer goes in.
  logic       rule_live [RULES];
  snrm_rule_t rule_slot [RULES];

  // Headers still owed by the block, oldest first.
  snrm_out_t nat_expected [$];

  int  mismatches = 0;
  int  items_sent = 0;
  // Set for a stretch of the random part: no gaps and no stalls at all.
  bit  quiet_io = 1'b0;

  // One row of the directed plan. Rows with typed set carry their expected
  // header; the rest are checked against the shadow table.
  typedef struct {
    snrm_in_t  item;
    bit        typed;
    snrm_out_t want;
  } nat_vec_t;

  localparam int N_DIRECTED = 21;

  nat_vec_t directed_plan [N_DIRECTED] = '{
    // after reset no rule is live: all-ones header passes through
    '{'{OP_XLATE, 4'hF, PROTO_TCP, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
        1'b1, 1'b1}, 1'b1,
      '{32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 4'd0}},
    // same with all-zero fields
    '{'{OP_XLATE, 4'h0, 8'h00, 32'h0, 16'h0, 32'h0, 16'h0, 1'b0, 1'b0}, 1'b1,
      '{32'h0, 16'h0, 32'h0, 16'h0, 1'b0, 4'd0}},
    // source NAT for TCP in slot 0; a write echoes its fields
    '{'{OP_WRITE, 4'd0, PROTO_TCP, 32'h0A00_0001, 16'h04D2, 32'hC633_6401, 16'h0050,
        1'b0, 1'b1}, 1'b1,
      '{32'h0A00_0001, 16'h04D2, 32'hC633_6401, 16'h0050, 1'b0, 4'd0}},
    '{'{OP_XLATE, 4'd0, PROTO_TCP, 32'h0A00_0001, 16'h04D2, 32'h0808_0808, 16'h01BB,
        1'b0, 1'b0}, 1'b0, NO_WANT},
    // destination NAT for UDP in the last slot, extreme match values
    '{'{OP_WRITE, 4'd15, PROTO_UDP, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0,
        1'b1, 1'b1}, 1'b1,
      '{32'hFFFF_FFFF, 16'hFFFF, 32'h0, 16'h0, 1'b0, 4'd0}},
    '{'{OP_XLATE, 4'd0, PROTO_UDP, 32'h0101_0101, 16'h0035, 32'hFFFF_FFFF, 16'hFFFF,
        1'b0, 1'b0}, 1'b0, NO_WANT},
    // destination NAT keys on the destination port: source port alone misses
    '{'{OP_XLATE, 4'd0, PROTO_UDP, 32'h0101_0101, 16'hFFFF, 32'hFFFF_FFFF, 16'h0035,
        1'b0, 1'b0}, 1'b0, NO_WANT},
    // protocol mismatch against slot 0
    '{'{OP_XLATE, 4'd0, PROTO_UDP, 32'h0A00_0001, 16'h04D2, 32'h0808_0808, 16'h01BB,
        1'b0, 1'b0}, 1'b0, NO_WANT},
    // portless protocol: rule port zero, packet port ignored and kept
    '{'{OP_WRITE, 4'd1, PROTO_ICMP, 32'h0102_0304, 16'h0000, 32'h0506_0708, 16'hABCD,
        1'b0, 1'b1}, 1'b1,
      '{32'h0102_0304, 16'h0000, 32'h0506_0708, 16'hABCD, 1'b0, 4'd0}},
    '{'{OP_XLATE, 4'd0, PROTO_ICMP, 32'h0102_0304, 16'h9999, 32'h0A0A_0A0A, 16'h7777,
        1'b0, 1'b0}, 1'b0, NO_WANT},
    // two rules with the same key: the lower slot wins
    '{'{OP_WRITE, 4'd4, PROTO_TCP, 32'h2222_2222, 16'h0007, 32'h3333_3333, 16'h0008,
        1'b0, 1'b1}, 1'b1,
      '{32'h2222_2222, 16'h0007, 32'h3333_3333, 16'h0008, 1'b0, 4'd0}},
    '{'{OP_WRITE, 4'd5, PROTO_TCP, 32'h2222_2222, 16'h0007, 32'h4444_4444, 16'h0009,
        1'b0, 1'b1}, 1'b1,
      '{32'h2222_2222, 16'h0007, 32'h4444_4444, 16'h0009, 1'b0, 4'd0}},
    '{'{OP_XLATE, 4'd0, PROTO_TCP, 32'h2222_2222, 16'h0007, 32'h5555_5555, 16'h0100,
        1'b0, 1'b0}, 1'b0, NO_WANT},
    // disable slot 4 by rewriting it with the enable low
    '{'{OP_WRITE, 4'd4, PROTO_TCP, 32'h2222_2222, 16'h0007, 32'h3333_3333, 16'h0008,
        1'b0, 1'b0}, 1'b1,
      '{32'h2222_2222, 16'h0007, 32'h3333_3333, 16'h0008, 1'b0, 4'd0}},
    '{'{OP_XLATE, 4'd0, PROTO_TCP, 32'h2222_2222, 16'h0007, 32'h5555_5555, 16'h0100,
        1'b0, 1'b0}, 1'b0, NO_WANT},
    // destination NAT on the top protocol number, no ports
    '{'{OP_WRITE, 4'd3, PROTO_RESERVED, 32'h0B0B_0B0B, 16'h0000, 32'h0C0C_0C0C, 16'hFFFF,
        1'b1, 1'b1}, 1'b1,
      '{32'h0B0B_0B0B, 16'h0000, 32'h0C0C_0C0C, 16'hFFFF, 1'b0, 4'd0}},
    '{'{OP_XLATE, 4'd0, PROTO_RESERVED, 32'h0D0D_0D0D, 16'h1234, 32'h0B0B_0B0B, 16'h5678,
        1'b0, 1'b0}, 1'b0, NO_WANT},
    // unused opcode aimed at slot 0: must not touch the table
    '{'{OP_UNUSED, 4'd0, PROTO_TCP, 32'h0A00_0001, 16'h04D2, 32'hDEAD_BEEF, 16'h1111,
        1'b1, 1'b0}, 1'b1,
      '{32'h0A00_0001, 16'h04D2, 32'hDEAD_BEEF, 16'h1111, 1'b0, 4'd0}},
    '{'{OP_XLATE, 4'd0, PROTO_TCP, 32'h0A00_0001, 16'h04D2, 32'h0808_0808, 16'h01BB,
        1'b0, 1'b0}, 1'b0, NO_WANT},
    // clear drops every valid mark
    '{'{OP_CLEAR, 4'd7, PROTO_UDP, 32'h1234_5678, 16'hBEEF, 32'h8765_4321, 16'hCAFE,
        1'b1, 1'b1}, 1'b1,
      '{32'h1234_5678, 16'hBEEF, 32'h8765_4321, 16'hCAFE, 1'b0, 4'd0}},
    '{'{OP_XLATE, 4'd0, PROTO_UDP, 32'h0101_0101, 16'h0035, 32'hFFFF_FFFF, 16'hFFFF,
        1'b0, 1'b0}, 1'b0, NO_WANT}
  };

  // Apply one transfer to the shadow table and return the header it yields.
  function automatic snrm_out_t apply_nat_item(input snrm_in_t it);
    snrm_out_t   hdr;
    logic        has_ports;
    logic [15:0] key_src_port;
    logic [15:0] key_dst_port;
    hdr = '{it.addr_a, it.port_a, it.addr_b, it.port_b, 1'b0, 4'd0};
    case (it.opcode)
      OP_WRITE: begin
        rule_live[it.rule_index] = it.rule_enable;
        rule_slot[it.rule_index] = '{dir: it.nat_direction, protocol: it.protocol,
                                     match_addr: it.addr_a, match_port: it.port_a,
                                     xlat_addr: it.addr_b, xlat_port: it.port_b};
      end
      OP_CLEAR: begin
        for (int i = 0; i < RULES; i++) rule_live[i] = 1'b0;
      end
      OP_XLATE: begin
        has_ports = (it.protocol == PROTO_TCP) || (it.protocol == PROTO_UDP);
        key_src_port = has_ports ? it.port_a : 16'h0;
        key_dst_port = has_ports ? it.port_b : 16'h0;
        for (int i = 0; i < RULES && !hdr.hit; i++) begin
          if (rule_live[i] && rule_slot[i].protocol == it.protocol) begin
            if (!rule_slot[i].dir) begin
              if (rule_slot[i].match_addr == it.addr_a &&
                  rule_slot[i].match_port == key_src_port) begin
                hdr.out_src_addr = rule_slot[i].xlat_addr;
                if (has_ports) hdr.out_src_port = rule_slot[i].xlat_port;
                hdr.hit = 1'b1;
              end
            end else if (rule_slot[i].match_addr == it.addr_b &&
                         rule_slot[i].match_port == key_dst_port) begin
              hdr.out_dst_addr = rule_slot[i].xlat_addr;
              if (has_ports) hdr.out_dst_port = rule_slot[i].xlat_port;
              hdr.hit = 1'b1;
            end
            if (hdr.hit) hdr.hit_index = i[3:0];
          end
        end
      end
      default: ;
    endcase
    return hdr;
  endfunction

  // Draw from a small pool half the time so keys collide and rules get hit.
  function automatic logic [31:0] pick_addr();
    return $urandom_range(1) ? $urandom : 32'h0A00_0000 + $urandom_range(3);
  endfunction

  function automatic logic [15:0] pick_port();
    return $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(2));
  endfunction

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(4))
      0, 1:    return PROTO_TCP;
      2:       return PROTO_UDP;
      3:       return PROTO_ICMP;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly translates, many of them built from a live rule so that they hit.
  function automatic snrm_in_t build_random_item();
    snrm_in_t it;
    int       pick;
    int       k;
    int       live [$];
    pick = $urandom_range(99);
    it.rule_index    = 4'($urandom_range(15));
    it.protocol      = pick_proto();
    it.addr_a        = pick_addr();
    it.port_a        = pick_port();
    it.addr_b        = pick_addr();
    it.port_b        = pick_port();
    it.nat_direction = 1'($urandom);
    it.rule_enable   = 1'($urandom);
    if (pick < 20) begin
      it.opcode      = OP_WRITE;
      it.rule_enable = ($urandom_range(9) != 0);
      // portless rules only match with a zero port
      if (it.protocol != PROTO_TCP && it.protocol != PROTO_UDP && $urandom_range(1))
        it.port_a = 16'h0;
    end else if (pick < 21) begin
      it.opcode = OP_CLEAR;
    end else if (pick < 23) begin
      it.opcode = OP_UNUSED;
    end else begin
      it.opcode = OP_XLATE;
      for (int i = 0; i < RULES; i++) if (rule_live[i]) live.push_back(i);
      if (live.size() > 0 && $urandom_range(9) < 7) begin
        k = live[$urandom_range(live.size() - 1)];
        it.protocol = rule_slot[k].protocol;
        if (!rule_slot[k].dir) begin
          it.addr_a = rule_slot[k].match_addr;
          it.port_a = rule_slot[k].match_port;
        end else begin
          it.addr_b = rule_slot[k].match_addr;
          it.port_b = rule_slot[k].match_port;
        end
        // near miss now and then
        if ($urandom_range(9) == 0) it.protocol = it.protocol ^ 8'h01;
      end
    end
    return it;
  endfunction

  // Offer one item, hold it until the block takes it, then log its header.
  task automatic send_item(input snrm_in_t it, input bit typed, input snrm_out_t want);
    snrm_out_t predicted;
    while (!quiet_io && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predicted = apply_nat_item(it);
    nat_expected.push_back(typed ? want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_header(input snrm_out_t got);
    snrm_out_t want;
    if (nat_expected.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual %h", $time, got);
      mismatches++;
    end else begin
      want = nat_expected.pop_front();
      compare_field("out_src_addr", want.out_src_addr, got.out_src_addr);
      compare_field("out_src_port", 32'(want.out_src_port), 32'(got.out_src_port));
      compare_field("out_dst_addr", want.out_dst_addr, got.out_dst_addr);
      compare_field("out_dst_port", 32'(want.out_dst_port), 32'(got.out_dst_port));
      compare_field("hit", 32'(want.hit), 32'(got.hit));
      compare_field("hit_index", 32'(want.hit_index), 32'(got.hit_index));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Check every result transfer against the oldest pending header.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_header(out_data);
  end

  // Result side: random stalls, one long hold-off to back the block up,
  // and none at all while the quiet stretch runs.
  initial begin
    int hold_left;
    bit held;
    out_stall = 1'b0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && items_sent >= HOLD_AFTER) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet_io && ($urandom_range(99) < 6);
      end
    end
  end

  // Give up when no transfer happens on either channel for too long.
  initial begin
    int stuck;
    stuck = 0;
    wait (rst_n === 1'b1);
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("FAILURE");
    $finish;
  end

  // Stimulus: reset, the directed plan, then the random run.
  initial begin
    for (int i = 0; i < RULES; i++) rule_live[i] = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i])
      send_item(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);

    for (int i = 0; i < N_RANDOM; i++) begin
      quiet_io = (i >= 500 && i < 700);
      send_item(build_random_item(), 1'b0, NO_WANT);
    end
    quiet_io = 1'b0;
    in_valid <= 1'b0;

    // Drain, then linger so a stray extra result still gets caught.
    while (nat_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
